// File: src/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// shared types and constants of the pairing table engine
// ----------------------------------------------------------------------------
package pte_pkg;

    localparam int ENTRIES   = 16;
    localparam int ID_BYTES  = 36;
    localparam int ID_BITS   = ID_BYTES * 8;
    localparam int KEY_BITS  = 256;
    localparam int SLOT_W    = 4;
    localparam int CNT_W     = 5;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_UPDATE = 3'd1,
        OP_REMOVE = 3'd2,
        OP_GET    = 3'd3,
        OP_COUNT  = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // request presented to every cell of the chain
    typedef struct packed {
        logic [2:0]         opcode;
        logic [5:0]         id_len;
        logic [ID_BITS-1:0] id;
        logic [KEY_BITS-1:0] key;
        logic [1:0]         perm;
    } req_t;

    // scan token handed from cell to cell
    typedef struct packed {
        logic               active;
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [1:0]         perm;
        logic [5:0]         len;
        logic [KEY_BITS-1:0] key;
        logic [CNT_W-1:0]   count;
    } tok_t;

    function automatic logic [ID_BITS-1:0] len_mask(input logic [5:0] len);
        logic [ID_BITS-1:0] m;
        for (int b = 0; b < ID_BYTES; b++)
        begin
            m[b*8 +: 8] = (6'(b) < len) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

// File: src/pte_cell.sv
// ----------------------------------------------------------------------------
// pte_cell
// one table slot; inspects the scan token and passes it on
// ----------------------------------------------------------------------------
module pte_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [pte_pkg::SLOT_W-1:0] slot_index,
    input  pte_pkg::req_t        req,
    input  logic                 step,
    input  pte_pkg::tok_t        tok_in,
    output pte_pkg::tok_t        tok_out
);

    logic [1:0]                  perm_reg;
    logic [5:0]                  len_reg;
    logic [pte_pkg::ID_BITS-1:0] id_reg;
    logic [pte_pkg::KEY_BITS-1:0] key_reg;

    logic match;
    logic occ;
    logic wr_add;
    logic wr_perm;
    logic [1:0] perm_val;

    assign occ   = (perm_reg != 2'd0);
    assign match = ((id_reg ^ req.id) & pte_pkg::len_mask(req.id_len)) == '0;

    always_comb
    begin
        tok_out  = tok_in;
        wr_add   = 1'b0;
        wr_perm  = 1'b0;
        perm_val = perm_reg;
        if (tok_in.active && step)
        begin
            case (req.opcode)
                pte_pkg::OP_ADD:
                begin
                    if (!occ)
                    begin
                        wr_add = 1'b1;
                        tok_out.active = 1'b0;
                        tok_out.hit = 1'b1;
                    end
                    else if (match)
                    begin
                        tok_out.active = 1'b0;
                        tok_out.hit = 1'b1;
                    end
                end
                pte_pkg::OP_UPDATE:
                begin
                    if (occ && match)
                    begin
                        wr_perm = 1'b1;
                        perm_val = req.perm;
                        tok_out.active = 1'b0;
                        tok_out.hit = 1'b1;
                    end
                end
                pte_pkg::OP_REMOVE:
                begin
                    if (match)
                    begin
                        wr_perm = 1'b1;
                        perm_val = 2'd0;
                        tok_out.active = 1'b0;
                    end
                end
                pte_pkg::OP_GET:
                begin
                    if (occ && match)
                    begin
                        tok_out.active = 1'b0;
                        tok_out.hit = 1'b1;
                        tok_out.slot = slot_index;
                        tok_out.perm = perm_reg;
                        tok_out.len = len_reg;
                        tok_out.key = key_reg;
                    end
                end
                pte_pkg::OP_COUNT:
                begin
                    if (occ && (req.perm == 2'd0 || req.perm == perm_reg))
                    begin
                        tok_out.count = tok_in.count + 1'b1;
                    end
                end
                pte_pkg::OP_CLEAR:
                begin
                    wr_perm = 1'b1;
                    perm_val = 2'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_reg <= 2'd0;
            len_reg  <= 6'd0;
            id_reg   <= '0;
        end
        else if (wr_add)
        begin
            perm_reg <= req.perm;
            len_reg  <= req.id_len;
            id_reg   <= req.id & pte_pkg::len_mask(req.id_len);
        end
        else if (wr_perm)
        begin
            perm_reg <= perm_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_add)
        begin
            key_reg <= req.key;
        end
    end

endmodule

// File: src/pairing_table_engine.sv
// ----------------------------------------------------------------------------
// pairing_table_engine
// table of controller records searched by identifier prefix
// ----------------------------------------------------------------------------
// A request is taken when idle; a scan token then walks the row of sixteen
// slot cells, one cell a cycle. The scan is followed by a done state, in which
// the response is registered, and then by the idle state, in which the next
// request is taken. The next request is taken while the previous response
// still waits in the output register; its own response then waits in the done
// state until the older one has been taken.
module pairing_table_engine
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, id_len, id_w0..id_w4, key_w0..key_w3 from the lowest bit up
    input  logic [559:0] s_tdata,
    // perm
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // ok, found_perm, found_id_len, found_slot, out_key_w0..w3, entry_count
    output logic [279:0] m_tdata
);

    localparam int N = pte_pkg::ENTRIES;

    pte_pkg::state_t state_reg, state_next;
    pte_pkg::req_t   req_reg;
    pte_pkg::tok_t   tok_reg, tok_next;
    pte_pkg::tok_t   tok_out [N];
    logic [pte_pkg::SLOT_W-1:0] pos_reg, pos_next;
    logic [279:0]    res_reg;
    logic            res_valid_reg;
    logic            accept, finish, bad;
    pte_pkg::tok_t   cur;
    logic [279:0]    res_next;

    assign accept = s_tvalid && s_tready;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            pte_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .slot_index (pte_pkg::SLOT_W'(g)),
                .req        (req_reg),
                .step       ((state_reg == pte_pkg::ST_SCAN) && (pos_reg == g)),
                .tok_in     (tok_reg),
                .tok_out    (tok_out[g])
            );
        end
    endgenerate

    assign cur = tok_out[pos_reg];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pte_pkg::ST_IDLE: if (accept) state_next = pte_pkg::ST_SCAN;
            pte_pkg::ST_SCAN: if (pos_reg == pte_pkg::SLOT_W'(N-1))
                                  state_next = pte_pkg::ST_DONE;
            pte_pkg::ST_DONE: if (!res_valid_reg || m_tready)
                                  state_next = pte_pkg::ST_IDLE;
            default:          state_next = pte_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == pte_pkg::ST_IDLE);
        finish   = (state_reg == pte_pkg::ST_DONE) && (!res_valid_reg || m_tready);
        pos_next = (state_reg == pte_pkg::ST_SCAN) ? pos_reg + 1'b1 : '0;
        if (state_reg == pte_pkg::ST_SCAN)
        begin
            tok_next = cur;
        end
        else if (accept)
        begin
            tok_next        = '0;
            tok_next.active = !((s_tdata[2:0] <= pte_pkg::OP_GET)
                                && (s_tdata[8:3] > 6'(pte_pkg::ID_BYTES)));
        end
        else
        begin
            tok_next = tok_reg;
        end
    end

    assign bad = (req_reg.opcode <= pte_pkg::OP_GET)
                 && (req_reg.id_len > 6'(pte_pkg::ID_BYTES));

    always_comb
    begin
        res_next = '0;
        case (req_reg.opcode) inside
            pte_pkg::OP_ADD, pte_pkg::OP_UPDATE: res_next[0] = tok_reg.hit;
            pte_pkg::OP_REMOVE, pte_pkg::OP_CLEAR: res_next[0] = 1'b1;
            pte_pkg::OP_GET:
            begin
                if (tok_reg.hit)
                begin
                    res_next[0]       = 1'b1;
                    res_next[2:1]     = tok_reg.perm;
                    res_next[8:3]     = tok_reg.len;
                    res_next[12:9]    = tok_reg.slot;
                    res_next[268:13]  = tok_reg.key;
                end
            end
            pte_pkg::OP_COUNT:
            begin
                res_next[0]       = 1'b1;
                res_next[273:269] = tok_reg.count;
            end
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pte_pkg::ST_IDLE;
            pos_reg       <= '0;
            tok_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            tok_reg   <= tok_next;
            if (finish)
                res_valid_reg <= 1'b1;
            else if (m_tready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.opcode <= s_tdata[2:0];
            req_reg.id_len <= s_tdata[8:3];
            req_reg.id     <= s_tdata[296:9];
            req_reg.key    <= s_tdata[552:297];
            req_reg.perm   <= s_tuser;
        end
        if (finish)
            res_reg <= bad ? '0 : res_next;
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = res_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == pte_pkg::ST_IDLE))
        else $error("ready outside idle");
    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pte_pkg::ST_IDLE) && accept |=> ##15 (state_reg == pte_pkg::ST_SCAN))
        else $error("scan length wrong");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        tok_reg.count <= 5'd16)
        else $error("count overflow");

endmodule
